[src/imq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_pkg
// Shared constants and codes of the indexed min priority queue.
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int CAPACITY_DEF       = 64;
  localparam int PRIORITY_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int ID_W     = 6;
  localparam int REQ_PR_W = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAME  = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_SIGNED   = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage
`default_nettype wire

[src/imq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_req_if / imq_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface imq_req_if
  import imq_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ID_W-1:0]     item_id;
  logic [REQ_PR_W-1:0] priority_req;

  modport source (output valid, opcode, item_id, priority_req, input ready);
  modport sink (input valid, opcode, item_id, priority_req, output ready);
endinterface

interface imq_rsp_if
  import imq_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [REQ_PR_W-1:0] out_priority;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_id, out_priority, entry_count, input ready);
  modport sink (input valid, status, out_id, out_priority, entry_count, output ready);
endinterface
`default_nettype wire

[src/indexed_min_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// Indexed binary min-heap with an id to slot map, one result per request.
// ----------------------------------------------------------------------------
// Each request (insert, pop minimum, update priority) is taken only while the
// sequencer is idle and yields one result. A request first passes the id map
// and slot lookup, then the moving entry walks the heap one level at a time:
// S_SWIM or S_SINK issues the registered memory read of the parent or of both
// children, and S_SWIM_CMP or S_SINK_CMP compares and writes one slot and one
// map entry. The result is then handed to the output register.
// The heap slots and the id map are memories with no reset; id presence is
// held in flip-flops cleared by reset, so no clearing pass is needed.
module indexed_min_priority_queue
  import imq_pkg::*;
#(
  parameter int CAPACITY       = CAPACITY_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  imq_req_if.sink             req,
  imq_rsp_if.source           rsp,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [APB_AW-1:0]   paddr,
  input  wire  [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int PW   = PRIORITY_WIDTH;
  localparam int XW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int NID  = (CAPACITY < (1 << ID_W)) ? CAPACITY : (1 << ID_W);
  localparam int IDXW = (NID > 1) ? $clog2(NID) : 1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PW-1:0]   prio;
  } slot_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOOK     = 8'b0000_0010,
    S_FETCH    = 8'b0000_0100,
    S_SWIM     = 8'b0000_1000,
    S_SWIM_CMP = 8'b0001_0000,
    S_SINK     = 8'b0010_0000,
    S_SINK_CMP = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  // configuration
  logic [CAP_W-1:0] cfg_cap;
  logic             cfg_signed;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cap    <= CAP_RESET;
      cfg_signed <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CAPACITY) begin
        cfg_cap <= pwdata[CAP_W-1:0];
      end else begin
        cfg_signed <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(cfg_cap);
    end else begin
      prdata = APB_DW'(cfg_signed);
    end
  end

  function automatic logic prio_less(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                     input logic sgn);
    logic [PW-1:0] flip;
    flip = '0;
    flip[PW-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

  // memories
  slot_t           heap_mem [CAPACITY];
  logic [XW-1:0]   pos_mem  [NID];
  slot_t           rd_a, rd_b;
  logic [XW-1:0]   pos_rd;
  logic [XW-1:0]   ra_a, ra_b, hw_addr;
  slot_t           hw_data;
  logic            hw_en;
  logic [IDXW-1:0] pa_rd, pa_wr;
  logic [XW-1:0]   pw_data;
  logic            pw_en;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    rd_a <= heap_mem[ra_a];
    rd_b <= heap_mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pa_wr] <= pw_data;
    end
    pos_rd <= pos_mem[pa_rd];
  end

  // sequencer registers
  state_t              state, state_next;
  logic [OP_W-1:0]     op_q, op_next;
  logic [ID_W-1:0]     id_q, id_next;
  logic [PW-1:0]       pr_q, pr_next;
  logic [ID_W-1:0]     e_id, e_id_next;
  logic [PW-1:0]       e_pr, e_pr_next;
  logic [XW-1:0]       x, x_next;
  logic [CW-1:0]       heap_count, heap_count_next;
  logic [NID-1:0]      id_present, id_present_next;
  logic [STATUS_W-1:0] status_q, status_next;
  logic [ID_W-1:0]     oid_q, oid_next;
  logic [PW-1:0]       opr_q, opr_next;
  logic                rsp_valid;

  logic [63:0]     req_pr64;
  logic [63:0]     opr64;
  logic [31:0]     cap32, l32, r32, p32;
  logic            id_ok, full;
  logic [IDXW-1:0] id_idx;
  slot_t           child;
  logic [31:0]     child32;
  logic            load_rsp;

  assign req_pr64 = 64'(req.priority_req);
  assign cap32    = (32'(cfg_cap) > CAPACITY) ? 32'(CAPACITY) : 32'(cfg_cap);
  assign id_ok    = 32'(id_q) < CAPACITY;
  assign id_idx   = id_q[IDXW-1:0];
  assign full     = 32'(heap_count) >= cap32;
  assign l32      = 2 * 32'(x) + 32'd1;
  assign r32      = 2 * 32'(x) + 32'd2;
  assign p32      = (32'(x) - 32'd1) >> 1;
  assign load_rsp = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_comb begin
    if ((r32 < 32'(heap_count)) && prio_less(rd_b.prio, rd_a.prio, cfg_signed)) begin
      child   = rd_b;
      child32 = r32;
    end else begin
      child   = rd_a;
      child32 = l32;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    op_next         = op_q;
    id_next         = id_q;
    pr_next         = pr_q;
    e_id_next       = e_id;
    e_pr_next       = e_pr;
    x_next          = x;
    heap_count_next = heap_count;
    id_present_next = id_present;
    status_next     = status_q;
    oid_next        = oid_q;
    opr_next        = opr_q;
    ra_a            = '0;
    ra_b            = '0;
    hw_en           = 1'b0;
    hw_addr         = x;
    hw_data         = '{id: e_id, prio: e_pr};
    pa_rd           = req.item_id[IDXW-1:0];
    pa_wr           = e_id[IDXW-1:0];
    pw_en           = 1'b0;
    pw_data         = x;

    case (state)
      S_IDLE: begin
        // map lookup at the request id and root read for pop
        if (req.valid) begin
          op_next    = req.opcode;
          id_next    = req.item_id;
          pr_next    = req_pr64[PW-1:0];
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ra_a        = pos_rd;
        status_next = ST_BADID;
        oid_next    = id_q;
        opr_next    = '0;
        state_next  = S_DONE;
        case (op_q)
          OP_INSERT: begin
            if (!id_ok) begin
              state_next = S_DONE;
            end else if (id_present[id_idx]) begin
              state_next = S_FETCH;
            end else if (full) begin
              status_next = ST_FULL;
              opr_next    = pr_q;
            end else begin
              status_next             = ST_OK;
              opr_next                = pr_q;
              e_id_next               = id_q;
              e_pr_next               = pr_q;
              x_next                  = XW'(heap_count);
              heap_count_next         = heap_count + 1'b1;
              id_present_next[id_idx] = 1'b1;
              state_next              = S_SWIM;
            end
          end
          OP_POP: begin
            if (heap_count == '0) begin
              status_next = ST_EMPTY;
              oid_next    = '0;
            end else begin
              status_next     = ST_OK;
              oid_next        = rd_a.id;
              opr_next        = rd_a.prio;
              id_present_next[rd_a.id[IDXW-1:0]] = 1'b0;
              heap_count_next = heap_count - 1'b1;
              ra_a            = XW'(heap_count - 1'b1);
              if (heap_count != CW'(1)) begin
                state_next = S_FETCH;
              end
            end
          end
          OP_UPDATE: begin
            if (id_ok && id_present[id_idx]) begin
              x_next     = pos_rd;
              state_next = S_FETCH;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_FETCH: begin
        state_next = S_DONE;
        case (op_q)
          OP_POP: begin
            // last entry goes into the root hole and sinks
            e_id_next  = rd_a.id;
            e_pr_next  = rd_a.prio;
            x_next     = '0;
            state_next = S_SINK;
          end
          OP_UPDATE: begin
            e_id_next = id_q;
            e_pr_next = pr_q;
            opr_next  = pr_q;
            if (prio_less(rd_a.prio, pr_q, cfg_signed)) begin
              status_next = ST_OK;
              state_next  = S_SINK;
            end else if (prio_less(pr_q, rd_a.prio, cfg_signed)) begin
              status_next = ST_OK;
              state_next  = S_SWIM;
            end else begin
              status_next = ST_SAME;
            end
          end
          default: begin
            // duplicate insert reports the stored priority
            opr_next = rd_a.prio;
          end
        endcase
      end
      S_SWIM: begin
        ra_a = XW'(p32);
        if (x == '0) begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SWIM_CMP;
        end
      end
      S_SWIM_CMP: begin
        if (prio_less(e_pr, rd_a.prio, cfg_signed)) begin
          hw_en      = 1'b1;
          hw_data    = rd_a;
          pw_en      = 1'b1;
          pa_wr      = rd_a.id[IDXW-1:0];
          x_next     = XW'(p32);
          state_next = S_SWIM;
        end else begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SINK: begin
        ra_a = XW'(l32);
        ra_b = XW'(r32);
        if (l32 >= 32'(heap_count)) begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SINK_CMP;
        end
      end
      S_SINK_CMP: begin
        if (prio_less(child.prio, e_pr, cfg_signed)) begin
          hw_en      = 1'b1;
          hw_data    = child;
          pw_en      = 1'b1;
          pa_wr      = child.id[IDXW-1:0];
          x_next     = XW'(child32);
          state_next = S_SINK;
        end else begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_count <= '0;
      id_present <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      heap_count <= heap_count_next;
      id_present <= id_present_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    id_q     <= id_next;
    pr_q     <= pr_next;
    e_id     <= e_id_next;
    e_pr     <= e_pr_next;
    x        <= x_next;
    status_q <= status_next;
    oid_q    <= oid_next;
    opr_q    <= opr_next;
  end

  // output register
  assign opr64 = 64'(opr_q);

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status       <= status_q;
      rsp.out_id       <= oid_q;
      rsp.out_priority <= opr64[REQ_PR_W-1:0];
      rsp.entry_count  <= COUNT_W'(heap_count);
    end
  end

  assign rsp.valid = rsp_valid;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(heap_count) <= CAPACITY)
    else $error("heap count beyond capacity");

  a_present_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(id_present) == 32'(heap_count)))
    else $error("present ids disagree with heap count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOOK) |=> $stable(heap_count))
    else $error("heap count changed outside lookup");
`endif

endmodule
`default_nettype wire
